// File: hdl/tcp_checksum_pseudo_header_unit_defines.svh
// ---------------------------------------------------------------------------
// TCP checksum unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TCP_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH
`define TCP_CHECKSUM_PSEUDO_HEADER_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define TCK_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// same-cycle implication
`define TCK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcp_ck_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum package
// Constants and the request record passed from accumulator to finalizer.
// ---------------------------------------------------------------------------
package tcp_ck_pkg;

  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] pad;
    logic [31:0] dest;
    logic [15:0] len;
    logic        too_long;
  } sum_req_t;

endpackage

// File: hdl/tcp_ck_seg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum segment byte channel
// One segment byte per request, with destination address and last marker.
// ---------------------------------------------------------------------------
interface tcp_ck_seg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_byte;
  logic [31:0] dest_ip;
  logic        last_byte;

  modport source (output valid, output seg_byte, output dest_ip, output last_byte,
                  input ready);
  modport sink   (input valid, input seg_byte, input dest_ip, input last_byte,
                  output ready);
endinterface

// File: hdl/tcp_ck_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum result channel
// One checksum, length and overflow flag per segment.
// ---------------------------------------------------------------------------
interface tcp_ck_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic [15:0] segment_length;
  logic        too_long;

  modport source (output valid, output checksum, output segment_length,
                  output too_long, input ready);
  modport sink   (input valid, input checksum, input segment_length,
                  input too_long, output ready);
endinterface

// File: hdl/tcp_ck_accum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum byte accumulator
// Pairs bytes into big-endian words, keeps the end-around-carry sum, byte
// count and captured destination; on the last byte issues a sum request.
// ---------------------------------------------------------------------------
`include "tcp_checksum_pseudo_header_unit_defines.svh"

module tcp_ck_accum (
  input  logic                clk,
  input  logic                rst_n,
  tcp_ck_seg_if.sink          in_chan,
  output tcp_ck_pkg::sum_req_t req_o,
  output logic                req_valid_o,
  input  logic                req_ready_i
);

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        odd_r, odd_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic        in_seg_r, in_seg_nxt;
  tcp_ck_pkg::sum_req_t req_r, req_nxt;
  logic        req_v_r, req_v_nxt;

  logic [15:0] sum_step;
  logic [7:0]  held_step;
  logic        odd_step;
  logic [15:0] cnt_step;
  logic        ovf_step;
  logic [31:0] dest_step;
  logic        accept;

  assign in_chan.ready = !req_v_r || req_ready_i;
  assign accept        = in_chan.valid && in_chan.ready;
  assign req_o         = req_r;
  assign req_valid_o   = req_v_r;

  always_comb begin
    dest_step = in_seg_r ? dest_r : in_chan.dest_ip;
    if (cnt_r == tcp_ck_pkg::LEN_MAX) begin
      cnt_step = cnt_r;
      ovf_step = 1'b1;
    end else begin
      cnt_step = cnt_r + 16'd1;
      ovf_step = ovf_r;
    end
    if (!odd_r) begin
      held_step = in_chan.seg_byte;
      odd_step  = 1'b1;
      sum_step  = sum_r;
    end else begin
      held_step = held_r;
      odd_step  = 1'b0;
      sum_step  = oc_add(sum_r, {held_r, in_chan.seg_byte});
    end

    sum_nxt    = sum_r;
    held_nxt   = held_r;
    odd_nxt    = odd_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    dest_nxt   = dest_r;
    in_seg_nxt = in_seg_r;
    req_nxt    = req_r;
    req_v_nxt  = req_v_r && !req_ready_i;

    if (accept) begin
      if (in_chan.last_byte) begin
        req_v_nxt        = 1'b1;
        req_nxt.acc      = sum_step;
        req_nxt.pad      = odd_step ? {held_step, 8'd0} : 16'd0;
        req_nxt.dest     = dest_step;
        req_nxt.len      = cnt_step;
        req_nxt.too_long = ovf_step;
        sum_nxt          = 16'd0;
        held_nxt         = 8'd0;
        odd_nxt          = 1'b0;
        cnt_nxt          = 16'd0;
        ovf_nxt          = 1'b0;
        dest_nxt         = 32'd0;
        in_seg_nxt       = 1'b0;
      end else begin
        sum_nxt    = sum_step;
        held_nxt   = held_step;
        odd_nxt    = odd_step;
        cnt_nxt    = cnt_step;
        ovf_nxt    = ovf_step;
        dest_nxt   = dest_step;
        in_seg_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= 16'd0;
      held_r   <= 8'd0;
      odd_r    <= 1'b0;
      cnt_r    <= 16'd0;
      ovf_r    <= 1'b0;
      dest_r   <= 32'd0;
      in_seg_r <= 1'b0;
      req_v_r  <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      held_r   <= held_nxt;
      odd_r    <= odd_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      dest_r   <= dest_nxt;
      in_seg_r <= in_seg_nxt;
      req_v_r  <= req_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  `TCK_ASSERT_ALWAYS(a_seg_cnt, clk, rst_n, in_seg_r == (cnt_r != 16'd0), "open segment without count")
  `TCK_ASSERT_IMPLIES(a_odd_cnt, clk, rst_n, !ovf_r, odd_r == cnt_r[0], "byte phase out of step")
  `TCK_ASSERT_NEXT(a_clear, clk, rst_n, accept && in_chan.last_byte, !in_seg_r && req_v_r, "segment not closed")
  `TCK_ASSERT_IMPLIES(a_sat, clk, rst_n, req_v_r && req_r.too_long, req_r.len == tcp_ck_pkg::LEN_MAX, "length not saturated")

endmodule

// File: hdl/tcp_ck_final.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum finalizer
// Adds the pseudo header words to the segment sum, folds, inverts and
// holds the result for the output channel.
// ---------------------------------------------------------------------------
module tcp_ck_final (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  tcp_ck_pkg::sum_req_t req_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  tcp_ck_res_if.source         out_chan
);

  logic [16:0] local_sum_r, local_sum_nxt;
  logic        out_v_r, out_v_nxt;
  logic [15:0] cks_r, cks_nxt;
  logic [15:0] len_r, len_nxt;
  logic        long_r, long_nxt;

  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        take;

  assign req_ready_o = !out_v_r || out_chan.ready;
  assign take        = req_valid_i && req_ready_o;

  assign local_sum_nxt = cfg_we ? ({1'b0, cfg_wdata[31:16]} + {1'b0, cfg_wdata[15:0]})
                                : local_sum_r;

  always_comb begin
    total = {3'd0, req_i.acc} + {3'd0, req_i.pad}
          + {3'd0, req_i.dest[31:16]} + {3'd0, req_i.dest[15:0]}
          + {3'd0, tcp_ck_pkg::PROTO_TCP} + {3'd0, req_i.len}
          + {2'd0, local_sum_r};
    fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};

    out_v_nxt = out_v_r && !out_chan.ready;
    cks_nxt   = cks_r;
    len_nxt   = len_r;
    long_nxt  = long_r;
    if (take) begin
      out_v_nxt = 1'b1;
      cks_nxt   = ~fold2;
      len_nxt   = req_i.len;
      long_nxt  = req_i.too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_sum_r <= 17'd0;
      out_v_r     <= 1'b0;
    end else begin
      local_sum_r <= local_sum_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cks_r  <= cks_nxt;
    len_r  <= len_nxt;
    long_r <= long_nxt;
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.checksum       = cks_r;
  assign out_chan.segment_length = len_r;
  assign out_chan.too_long       = long_r;

endmodule

// File: hdl/tcp_checksum_pseudo_header_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP checksum unit with IPv4 pseudo header
// Streams segment bytes, returns inverted ones' complement checksum,
// saturated length and overflow flag per segment.
// ---------------------------------------------------------------------------
//  port      dir   content
//  in_chan   sink  seg_byte[8], dest_ip[32], last_byte
//  out_chan  src   checksum[16], segment_length[16], too_long
//  cfg_*     in    cfg_we, cfg_wdata[32] -> local IPv4 address
//
// One byte accepted per cycle unless stalled. Two register stages: the
// accumulator request register loads with the last byte, and the output
// register loads when the finalizer takes the request, raising out_chan.valid.
// Synchronous active-low reset clears segment state and the local address.
// A stalled result holds in the output register; one more finished segment
// waits in the accumulator register, then in_chan.ready drops.
// ---------------------------------------------------------------------------
module tcp_checksum_pseudo_header_unit (
  input  logic         clk,
  input  logic         rst_n,
  tcp_ck_seg_if.sink   in_chan,
  tcp_ck_res_if.source out_chan,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  tcp_ck_pkg::sum_req_t req;
  logic                 req_valid;
  logic                 req_ready;

  tcp_ck_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready)
  );

  tcp_ck_final u_final (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .out_chan    (out_chan)
  );

endmodule
